@@ rtl/core/tfw_pkg.sv @@
// Shared types, constants and the identifier decoder for the tag frame walker.
package tfw_pkg;

   localparam int unsigned HEADER_BYTES = 10;
   localparam int unsigned FIELD_W      = 4;
   localparam int unsigned SIZE_W       = 29;
   localparam int unsigned KIND_W       = 3;

   localparam logic [FIELD_W-1:0] HEADER_LAST = FIELD_W'(HEADER_BYTES);
   localparam logic [FIELD_W-1:0] ID_BYTES    = 4'd4;
   localparam logic [FIELD_W-1:0] SIZE_BYTES  = 4'd4;
   localparam logic [FIELD_W-1:0] FLAG_BYTES  = 4'd2;

   localparam logic [7:0] MAX_FRAMES_RESET = 8'd6;
   localparam logic [7:0] FRAMES_SAT       = 8'd255;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_ID,
      PH_SIZE,
      PH_FLAGS,
      PH_BODY,
      PH_DONE
   } phase_type;

   localparam phase_type RESTART_PHASE = (HEADER_BYTES > 0) ? PH_HEADER : PH_ID;

   localparam logic [KIND_W-1:0] KIND_TITLE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ARTIST  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ALBUM   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_YEAR    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_GENRE   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_COMMENT = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd7;

   localparam logic [31:0] ID_TIT2 = "TIT2";
   localparam logic [31:0] ID_TPE1 = "TPE1";
   localparam logic [31:0] ID_TALB = "TALB";
   localparam logic [31:0] ID_TDRC = "TDRC";
   localparam logic [31:0] ID_TYER = "TYER";
   localparam logic [31:0] ID_TCON = "TCON";
   localparam logic [31:0] ID_COMM = "COMM";

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] frame_kind;
      logic [7:0]        text_byte;
      logic              text_ended;
      logic              last_of_frame;
   } rsp_type;

   // One result of a parse step, travels from the parser to the output stage.
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } emit_type;

   function automatic logic [KIND_W-1:0] kind_of(input logic [31:0] ident);
      logic [KIND_W-1:0] kind;
      kind = KIND_UNKNOWN;
      case (ident)
         ID_TIT2: kind = KIND_TITLE;
         ID_TPE1: kind = KIND_ARTIST;
         ID_TALB: kind = KIND_ALBUM;
         ID_TDRC: kind = KIND_YEAR;
         ID_TYER: kind = KIND_YEAR;
         ID_TCON: kind = KIND_GENRE;
         ID_COMM: kind = KIND_COMMENT;
         default: kind = KIND_UNKNOWN;
      endcase
      return kind;
   endfunction

endpackage

@@ rtl/core/tag_frame_walker.sv @@
// Top level of the tag frame walker: byte stream in, text frame bytes out.
//
//   Channel   Direction  Handshake              Carries
//   req_      in         req_valid/req_ready    req_payload: data_byte, file_start
//   rsp_      out        rsp_valid/rsp_ready    rsp_payload: frame_kind, text_byte,
//                                               text_ended, last_of_frame
//   csr_      in         csr_wr_en              csr_wr_data: max_frames
//
// One byte per cycle while req_ready is high: each byte is parsed in the cycle it
// is accepted; any result appears on rsp_ the next cycle from the result register.
// req_ready stays high while the result register is empty or is being drained.
// A full result register under a stalled consumer holds every input byte, text
// or not, until the consumer takes the waiting transaction.
// Reset is synchronous; it clears the parse state, empties the result register
// and sets max_frames to 6.
module tag_frame_walker (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  tfw_pkg::req_type    req_payload,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tfw_pkg::rsp_type    rsp_payload,

   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data
);

   logic [7:0]        max_frames_ff;
   logic              step;
   logic              space;
   tfw_pkg::emit_type emit;

   // frame limit register; a new value applies at the next frame boundary
   always_ff @(posedge clock) begin
      if (reset) begin
         max_frames_ff <= tfw_pkg::MAX_FRAMES_RESET;
      end else if (csr_wr_en) begin
         max_frames_ff <= csr_wr_data;
      end
   end

   // accept whenever the result register can take what this byte produces
   assign req_ready = space;
   assign step      = req_valid && req_ready;

   tfw_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .req_data   (req_payload),
      .max_frames (max_frames_ff),
      .emit       (emit)
   );

   // load only on an accepted byte that yields text
   tfw_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (step && emit.valid),
      .load_data   (emit.data),
      .space       (space),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   // an empty result register never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty result register");

   // only known text frames produce transactions
   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.frame_kind <= tfw_pkg::KIND_COMMENT))
      else $error("result carries an unknown frame kind");

   // a zero text byte always marks the text as ended
   a_zero_marks_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.text_byte == 8'd0) |-> rsp_payload.text_ended)
      else $error("zero text byte without text_ended");

   // an accepted text byte shows up as a result on the next cycle
   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      (step && emit.valid) |=> rsp_valid)
      else $error("accepted text byte did not reach the result register");
`endif

endmodule

@@ rtl/core/tfw_parser.sv @@
// Parse state registers and the combinational next-state and result logic.
module tfw_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  tfw_pkg::req_type    req_data,
   input  logic [7:0]          max_frames,
   output tfw_pkg::emit_type   emit
);

   tfw_pkg::phase_type               phase_ff, phase_in, phase_cur;
   logic [tfw_pkg::FIELD_W-1:0]      count_ff, count_in, count_cur, count_inc;
   logic [31:0]                      ident_ff, ident_in, ident_cur;
   logic [tfw_pkg::SIZE_W-1:0]       size_ff, size_in, size_cur, size_part, size_new;
   logic [tfw_pkg::SIZE_W-1:0]       remain_ff, remain_in, remain_cur;
   logic [7:0]                       frames_ff, frames_in, frames_cur;
   logic [tfw_pkg::KIND_W-1:0]       kind_ff, kind_in, kind_cur;
   logic                             zero_ff, zero_in, zero_cur;
   logic [7:0]                       byte_val;
   logic                             is_encoding, is_last, zero_now;

   assign byte_val = req_data.data_byte;

   always_comb begin
      // restart on a file start byte, which is then parsed as the first byte
      if (req_data.file_start) begin
         phase_cur  = tfw_pkg::RESTART_PHASE;
         count_cur  = '0;
         ident_cur  = '0;
         size_cur   = '0;
         remain_cur = '0;
         frames_cur = '0;
         kind_cur   = tfw_pkg::KIND_UNKNOWN;
         zero_cur   = 1'b0;
      end else begin
         phase_cur  = phase_ff;
         count_cur  = count_ff;
         ident_cur  = ident_ff;
         size_cur   = size_ff;
         remain_cur = remain_ff;
         frames_cur = frames_ff;
         kind_cur   = kind_ff;
         zero_cur   = zero_ff;
      end

      count_inc = count_cur + 1'b1;

      // size bytes land at bit 21, 14, 7, 0; bit 7 of each lower byte overlaps unmasked
      case (count_cur[1:0])
         2'd0:    size_part = {byte_val, 21'd0};
         2'd1:    size_part = {7'd0, byte_val, 14'd0};
         2'd2:    size_part = {14'd0, byte_val, 7'd0};
         default: size_part = {21'd0, byte_val};
      endcase
      size_new = size_cur | size_part;

      is_encoding = (remain_cur == size_cur);
      is_last     = (remain_cur[tfw_pkg::SIZE_W-1:1] == '0);
      zero_now    = zero_cur | (byte_val == 8'd0);

      phase_in  = phase_cur;
      count_in  = count_cur;
      ident_in  = ident_cur;
      size_in   = size_cur;
      remain_in = remain_cur;
      frames_in = frames_cur;
      kind_in   = kind_cur;
      zero_in   = zero_cur;

      emit.valid              = 1'b0;
      emit.data.frame_kind    = kind_cur;
      emit.data.text_byte     = byte_val;
      emit.data.text_ended    = zero_now;
      emit.data.last_of_frame = is_last;

      unique case (phase_cur)
         tfw_pkg::PH_HEADER: begin
            count_in = count_inc;
            if (count_inc >= tfw_pkg::HEADER_LAST) begin
               phase_in = tfw_pkg::PH_ID;
               count_in = '0;
            end
         end
         tfw_pkg::PH_ID: begin
            if (count_cur == '0 && frames_cur >= max_frames) begin
               phase_in = tfw_pkg::PH_DONE;
            end else begin
               ident_in = {ident_cur[23:0], byte_val};
               count_in = count_inc;
               if (count_inc >= tfw_pkg::ID_BYTES) begin
                  phase_in = tfw_pkg::PH_SIZE;
                  count_in = '0;
                  size_in  = '0;
               end
            end
         end
         tfw_pkg::PH_SIZE: begin
            size_in  = size_new;
            count_in = count_inc;
            if (count_inc >= tfw_pkg::SIZE_BYTES) begin
               count_in = '0;
               if (size_new == '0) begin
                  phase_in = tfw_pkg::PH_DONE;
               end else begin
                  phase_in = tfw_pkg::PH_FLAGS;
                  kind_in  = tfw_pkg::kind_of(ident_cur);
                  zero_in  = 1'b0;
               end
            end
         end
         tfw_pkg::PH_FLAGS: begin
            count_in = count_inc;
            if (count_inc >= tfw_pkg::FLAG_BYTES) begin
               count_in  = '0;
               phase_in  = tfw_pkg::PH_BODY;
               remain_in = size_cur;
            end
         end
         tfw_pkg::PH_BODY: begin
            // drop the encoding byte and every byte of an unknown frame
            if (!is_encoding && kind_cur != tfw_pkg::KIND_UNKNOWN) begin
               emit.valid = 1'b1;
               zero_in    = zero_now;
            end
            if (is_last) begin
               remain_in = '0;
               if (frames_cur < tfw_pkg::FRAMES_SAT) begin
                  frames_in = frames_cur + 1'b1;
               end
               phase_in = tfw_pkg::PH_ID;
               count_in = '0;
               ident_in = '0;
            end else begin
               remain_in = remain_cur - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= tfw_pkg::RESTART_PHASE;
         count_ff  <= '0;
         ident_ff  <= '0;
         size_ff   <= '0;
         remain_ff <= '0;
         frames_ff <= '0;
         kind_ff   <= tfw_pkg::KIND_UNKNOWN;
         zero_ff   <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         ident_ff  <= ident_in;
         size_ff   <= size_in;
         remain_ff <= remain_in;
         frames_ff <= frames_in;
         kind_ff   <= kind_in;
         zero_ff   <= zero_in;
      end
   end

endmodule

@@ rtl/core/tfw_out_stage.sv @@
// Result register that holds one transaction until the consumer takes it.
module tfw_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  tfw_pkg::rsp_type    load_data,
   output logic                space,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tfw_pkg::rsp_type    rsp_payload
);

   logic             valid_ff, valid_in;
   tfw_pkg::rsp_type data_ff;

   assign space       = !valid_ff || rsp_ready;
   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

@@ dv/tag_frame_walker_checker.sv @@
`timescale 1ns / 100ps
// Checker for the tag frame walker: tracks the byte parse and compares text results.
module tag_frame_walker_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  tfw_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  tfw_pkg::rsp_type rsp_payload,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   output int               fail_count,
   output int               pending
);

   // Parser shadow state
   tfw_pkg::phase_type          stage;
   logic [tfw_pkg::FIELD_W-1:0] byte_count;
   logic [31:0]                 ident_shift;
   logic [tfw_pkg::SIZE_W-1:0]  size_word;
   logic [tfw_pkg::SIZE_W-1:0]  body_left;
   logic [7:0]                  frames_walked;
   logic [tfw_pkg::KIND_W-1:0]  text_kind;
   logic                        null_seen;
   logic [7:0]                  frame_limit;

   tfw_pkg::rsp_type            text_q[$];
   int                          mismatches = 0;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report(input string msg);
      $display("[%0t] tfw check: %s", $time, msg);
      mismatches++;
   endtask

   function automatic logic [tfw_pkg::KIND_W-1:0] ident_to_kind(input logic [31:0] ident);
      if (ident == "TIT2") return tfw_pkg::KIND_TITLE;
      if (ident == "TPE1") return tfw_pkg::KIND_ARTIST;
      if (ident == "TALB") return tfw_pkg::KIND_ALBUM;
      if (ident == "TDRC" || ident == "TYER") return tfw_pkg::KIND_YEAR;
      if (ident == "TCON") return tfw_pkg::KIND_GENRE;
      if (ident == "COMM") return tfw_pkg::KIND_COMMENT;
      return tfw_pkg::KIND_UNKNOWN;
   endfunction

   task automatic rewind_parse();
      stage         = tfw_pkg::RESTART_PHASE;
      byte_count    = '0;
      ident_shift   = '0;
      size_word     = '0;
      body_left     = '0;
      frames_walked = '0;
      text_kind     = tfw_pkg::KIND_UNKNOWN;
      null_seen     = 1'b0;
   endtask

   // Advance the shadow parser by one byte; queue a text result if one is due.
   task automatic parse_byte(input tfw_pkg::req_type item);
      logic [7:0]       value;
      logic             is_encoding;
      logic             is_last;
      int               shift;
      tfw_pkg::rsp_type text;
      value = item.data_byte;
      if (item.file_start)
         rewind_parse();
      case (stage)
         tfw_pkg::PH_HEADER: begin
            byte_count = byte_count + 1'b1;
            if (byte_count >= tfw_pkg::HEADER_LAST) begin
               stage      = tfw_pkg::PH_ID;
               byte_count = '0;
            end
         end
         tfw_pkg::PH_ID: begin
            if (byte_count == '0 && frames_walked >= frame_limit) begin
               stage = tfw_pkg::PH_DONE;
            end else begin
               ident_shift = {ident_shift[23:0], value};
               byte_count  = byte_count + 1'b1;
               if (byte_count >= tfw_pkg::ID_BYTES) begin
                  stage      = tfw_pkg::PH_SIZE;
                  byte_count = '0;
                  size_word  = '0;
               end
            end
         end
         tfw_pkg::PH_SIZE: begin
            // bit 7 is kept, so neighboring bytes may overlap
            shift      = 21 - 7 * int'(byte_count);
            size_word  = size_word | (tfw_pkg::SIZE_W'(value) << shift);
            byte_count = byte_count + 1'b1;
            if (byte_count >= tfw_pkg::SIZE_BYTES) begin
               byte_count = '0;
               if (size_word == '0) begin
                  stage = tfw_pkg::PH_DONE;
               end else begin
                  stage     = tfw_pkg::PH_FLAGS;
                  text_kind = ident_to_kind(ident_shift);
                  null_seen = 1'b0;
               end
            end
         end
         tfw_pkg::PH_FLAGS: begin
            byte_count = byte_count + 1'b1;
            if (byte_count >= tfw_pkg::FLAG_BYTES) begin
               byte_count = '0;
               stage      = tfw_pkg::PH_BODY;
               body_left  = size_word;
            end
         end
         tfw_pkg::PH_BODY: begin
            is_encoding = (body_left == size_word);
            is_last     = (body_left <= 1);
            if (!is_encoding && text_kind != tfw_pkg::KIND_UNKNOWN) begin
               if (value == 8'h00)
                  null_seen = 1'b1;
               text.frame_kind    = text_kind;
               text.text_byte     = value;
               text.text_ended    = null_seen;
               text.last_of_frame = is_last;
               text_q.push_back(text);
            end
            if (is_last) begin
               body_left = '0;
               if (frames_walked < tfw_pkg::FRAMES_SAT)
                  frames_walked = frames_walked + 1'b1;
               stage       = tfw_pkg::PH_ID;
               byte_count  = '0;
               ident_shift = '0;
            end else begin
               body_left = body_left - 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_text(input tfw_pkg::rsp_type seen);
      tfw_pkg::rsp_type want;
      if (text_q.size() == 0) begin
         report($sformatf("text byte %02h with none predicted", seen.text_byte));
         return;
      end
      want = text_q.pop_front();
      if (seen.frame_kind !== want.frame_kind)
         report($sformatf("frame_kind %0d, predicted %0d", seen.frame_kind, want.frame_kind));
      if (seen.text_byte !== want.text_byte)
         report($sformatf("text_byte %02h, predicted %02h", seen.text_byte, want.text_byte));
      if (seen.text_ended !== want.text_ended)
         report($sformatf("text_ended %b, predicted %b", seen.text_ended, want.text_ended));
      if (seen.last_of_frame !== want.last_of_frame)
         report($sformatf("last_of_frame %b, predicted %b",
                          seen.last_of_frame, want.last_of_frame));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rewind_parse();
         frame_limit = tfw_pkg::MAX_FRAMES_RESET;
         text_q.delete();
      end else begin
         if (csr_wr_en)
            frame_limit = csr_wr_data;
         // a result appears on rsp_ the cycle after its byte is accepted, so drain before parsing
         if (rsp_valid && rsp_ready)
            check_text(rsp_payload);
         if (req_valid && req_ready)
            parse_byte(req_payload);
      end
      pending    <= text_q.size();
      fail_count <= mismatches;
   end

endmodule

@@ dv/tag_frame_walker_test.sv @@
`timescale 1ns / 100ps
// Testbench top for the tag frame walker: byte stimulus, frame limit phases and verdict.
module tag_frame_walker_test;

   // Receiver hold-off that backs the block up into its input
   localparam int HOLD_AFTER  = 60;
   localparam int HOLD_CYCLES = 120;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   tfw_pkg::req_type req_payload = '0;
   logic             rsp_ready   = 1'b0;
   logic             csr_wr_en   = 1'b0;
   logic [7:0]       csr_wr_data = tfw_pkg::MAX_FRAMES_RESET;

   logic             req_ready;
   logic             rsp_valid;
   tfw_pkg::rsp_type rsp_payload;
   int               fail_count;
   int               pending;

   // Stimulus bookkeeping
   bit         calm       = 1'b0;   // no idling on either side once set
   bit         counting   = 1'b1;   // byte is one the parser actually uses
   int         live_items = 0;
   int         frame_cap  = tfw_pkg::MAX_FRAMES_RESET;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tag_frame_walker uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tag_frame_walker_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // Text body byte: nulls show up often so text_ended gets exercised.
   function automatic logic [7:0] body_byte();
      return ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom);
   endfunction

   function automatic logic [31:0] known_ident(input int pick);
      case (pick)
         0:       return tfw_pkg::ID_TIT2;
         1:       return tfw_pkg::ID_TPE1;
         2:       return tfw_pkg::ID_TALB;
         3:       return tfw_pkg::ID_TDRC;
         4:       return tfw_pkg::ID_TYER;
         5:       return tfw_pkg::ID_TCON;
         default: return tfw_pkg::ID_COMM;
      endcase
   endfunction

   // Offer one byte and hold it until the block takes the transaction.
   // A random gap may come first; valid drops only for the gap.
   task automatic send_byte(input logic [7:0] value, input logic restart);
      int gap;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: value, file_start: restart};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (counting)
         live_items++;
   endtask

   // Tag header: the first byte flags a new file.
   task automatic send_header(input int count);
      send_byte(8'($urandom), 1'b1);
      repeat (count - 1) send_byte(8'($urandom), 1'b0);
   endtask

   // Identifier, size field and two flag bytes, most significant byte first.
   task automatic send_frame_head(input logic [31:0] ident, input logic [31:0] size_bytes);
      for (int i = 3; i >= 0; i--)
         send_byte(ident[8*i +: 8], 1'b0);
      for (int i = 3; i >= 0; i--)
         send_byte(size_bytes[8*i +: 8], 1'b0);
      repeat (2) send_byte(8'($urandom), 1'b0);
   endtask

   // Write the frame limit with the block idle: stop offering, let every
   // predicted text byte drain, then allow the pipeline to settle.
   task automatic set_frame_cap(input logic [7:0] value);
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      frame_cap = value;
   endtask

   // One file with random content. Most are well formed; some are cut short
   // in the header or inside a body so that the next file restarts the walk.
   task automatic send_random_file();
      int          frames;
      int          pick;
      int          body_len;
      logic [31:0] ident;
      logic [31:0] size_bytes;
      logic [7:0]  low_size;
      counting = 1'b1;
      if ($urandom_range(0, 19) == 0) begin
         send_header($urandom_range(1, tfw_pkg::HEADER_BYTES - 1));
         return;
      end
      send_header(tfw_pkg::HEADER_BYTES);
      frames = $urandom_range(1, 8);
      for (int f = 0; f < frames; f++) begin
         if (f >= frame_cap) begin
            // limit reached: the parse stops and ignores the rest
            counting = 1'b0;
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
            return;
         end
         pick = $urandom_range(0, 9);
         if (pick < 7)
            ident = known_ident($urandom_range(0, 6));
         else if (pick < 9)
            ident = known_ident($urandom_range(0, 6)) ^ (32'h1 << $urandom_range(0, 31));
         else
            ident = $urandom;
         pick = $urandom_range(0, 19);
         if (pick < 17) begin
            body_len   = $urandom_range(1, 12);
            size_bytes = 32'(body_len);
         end else if (pick < 19) begin
            // low size byte with bit 7 set overlaps the next byte's field
            low_size   = 8'h80 | 8'($urandom_range(0, 127));
            size_bytes = {16'h0, 7'h0, 1'($urandom), low_size};
            body_len   = int'(size_bytes[15:8] << 7) | int'(low_size);
         end else begin
            // huge size: walk a few body bytes, then restart with a new file
            send_frame_head(ident, $urandom);
            repeat ($urandom_range(0, 6)) send_byte(body_byte(), 1'b0);
            return;
         end
         send_frame_head(ident, size_bytes);
         repeat (body_len) send_byte(body_byte(), 1'b0);
      end
      if ($urandom_range(0, 2) == 0) begin
         // zero size terminates; trailing bytes are dropped by the block
         send_frame_head($urandom, 32'h0);
         counting = 1'b0;
         repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
      end
   endtask

   // Receiver: random stall bursts, one long hold-off once traffic is flowing.
   initial begin : receiver
      int burst;
      int taken;
      bit held;
      taken = 0;
      held  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            taken++;
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (!held && taken >= HOLD_AFTER) begin
            // hold off long enough for the result register to back up input
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 18);
            rsp_ready <= 1'b0;
            repeat (burst - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus and verdict
   initial begin : stimulus
      int          target;
      logic [7:0]  cap_plan [6];
      cap_plan = '{8'd255, 8'd1, 8'd3, tfw_pkg::MAX_FRAMES_RESET, 8'd2, 8'd0};
      cap_plan[5] = 8'($urandom_range(1, 255));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Header with both byte extremes, a text frame holding 0xFF and a
      // null, an unknown frame, an encoding-only frame, then a zero size
      // that ends the parse so the trailing byte is dropped.
      send_byte(8'hFF, 1'b1);
      repeat (tfw_pkg::HEADER_BYTES - 2) send_byte(8'($urandom), 1'b0);
      send_byte(8'h00, 1'b0);
      send_frame_head(tfw_pkg::ID_TIT2, 32'd4);
      send_byte(8'h03, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h41, 1'b0);
      send_frame_head("XYZ9", 32'd2);
      send_byte(8'h00, 1'b0);
      send_byte(8'h55, 1'b0);
      send_frame_head(tfw_pkg::ID_COMM, 32'd1);
      send_byte(8'h01, 1'b0);
      send_frame_head(tfw_pkg::ID_TYER, 32'd0);
      send_byte(8'hA5, 1'b0);

      // Size bytes all with bit 7 set: overlapping fields, huge body.
      // Restart inside that body with the next file.
      send_header(tfw_pkg::HEADER_BYTES);
      send_frame_head(tfw_pkg::ID_TALB, 32'h80FF80FF);
      repeat (3) send_byte(body_byte(), 1'b0);

      // Frame limit of zero: the parse ends right after the header
      set_frame_cap(8'd0);
      send_header(tfw_pkg::HEADER_BYTES);
      send_frame_head(tfw_pkg::ID_TPE1, 32'd3);

      // Random files across several frame limits; no idling in the last phase
      foreach (cap_plan[p]) begin
         if (p == 5)
            calm = 1'b1;
         set_frame_cap(p == 5 ? cap_plan[5] : cap_plan[p]);
         target = live_items + 60;
         while (live_items < target)
            send_random_file();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Guard against a hang: drop the run after a generous time
   initial begin : watchdog
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/tfw_pkg.sv
rtl/core/tfw_parser.sv
rtl/core/tfw_out_stage.sv
rtl/core/tag_frame_walker.sv
dv/tag_frame_walker_checker.sv
dv/tag_frame_walker_test.sv
